>>> sv/lkv_pkg.sv
// Package with field widths, codes and constants of the LRU key/value cache.
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request kinds carried in tuser.
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;

	// Value returned on a get miss and for every set.
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// What the update pass does to the memory.
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_NONE    = 2'd0;
	localparam mode_t MODE_PROMOTE = 2'd1;
	localparam mode_t MODE_INSERT  = 2'd2;

endpackage

>>> sv/lru_key_value_cache.sv
// Top level of the LRU key/value cache: entry memory, scan, decision and update sequencer.
`timescale 1ns / 1ps

// Fully associative key/value store of MAX_ENTRIES pairs with least-recently-used
// replacement. All entries (valid bit, recency rank, key, value) live in one
// synchronous memory with a registered read. A request is taken in the idle state
// and handled one at a time: a scan pass reads every entry to find the key, the
// first free slot and the least recent entry, a decision state follows, then an
// update pass reads and writes back every entry to move the ranks, and a finish
// state loads the result. A get miss, or a set dropped at capacity zero, skips
// the update pass. After reset a clearing pass clears the valid bits, and no
// request is accepted during it; capacity writes are taken at any time. A new
// request may be accepted while the previous result still waits in the output
// register.
module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int MAX_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	// Capacity register write channel.
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data,
	// Requests. tdata: key [31:0], value [63:32]. tuser: action [0].
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [63:0]      s_axis_tdata,
	input  logic             s_axis_tuser,
	// Results. tdata: read_value [31:0], evicted [32], zero [39:33]. tuser: hit [0].
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [39:0]      m_axis_tdata,
	output logic             m_axis_tuser
);

	localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = ((CW > CAP_W) ? CW : CAP_W) + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
	localparam logic [CW-1:0] END_CNT  = CW'(MAX_ENTRIES);

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	typedef struct packed {
		logic             valid;
		logic [IW-1:0]    rank;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	logic [2:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic [CAP_W-1:0]  capacity_q;
	logic [CW-1:0]     count_q;

	// Request registers.
	logic              act_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;

	// Entry memory and its read pipeline.
	entry_t            entry_mem_q [MAX_ENTRIES];
	entry_t            mem_rd_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic              rd_issue;
	logic [IW-1:0]     mem_ra;
	logic              mem_we;
	logic [IW-1:0]     mem_wa;
	entry_t            mem_wd;
	entry_t            upd_word;

	// Scan results.
	logic              match_q;
	logic [IW-1:0]     match_idx_q;
	logic [IW-1:0]     match_rank_q;
	logic [VAL_W-1:0]  match_val_q;
	logic              free_q;
	logic [IW-1:0]     free_idx_q;
	logic              vic_q;
	logic [IW-1:0]     vic_idx_q;
	logic [IW-1:0]     vic_rank_q;

	// Decision registers.
	mode_t             mode_q;
	logic [IW-1:0]     ins_idx_q;
	logic              vic_en_q;
	logic              res_hit_q;
	logic [VAL_W-1:0]  res_rd_q;
	logic              res_ev_q;

	// Output register.
	logic              out_valid_q;
	logic              out_hit_q;
	logic [VAL_W-1:0]  out_rd_q;
	logic              out_ev_q;

	// Decision logic.
	logic [CMPW-1:0]   cap_eff;
	logic              over_cap;
	mode_t             mode_d;
	logic              vic_en_d;
	logic [IW-1:0]     ins_idx_d;
	logic [CW-1:0]     count_d;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = {7'd0, out_ev_q, out_rd_q};

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Memory port control: the clearing pass and the update pass write, the scan and update passes read.
	assign rd_issue = ((state_q == ST_SCAN) || (state_q == ST_UPDATE)) && (cnt_q != END_CNT);
	assign mem_ra   = rd_issue ? cnt_q[IW-1:0] : '0;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = upd_word;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = cnt_q[IW-1:0];
			mem_wd = '0;
		end else if (state_q == ST_UPDATE) begin
			mem_we = vld_s1;
		end
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_wa] <= mem_wd;
		end
		mem_rd_q <= entry_mem_q[mem_ra];
	end

	// Read pipeline tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			vld_s1 <= rd_issue;
			idx_s1 <= cnt_q[IW-1:0];
		end
	end

	// New contents of the entry that the update pass has just read.
	always_comb begin
		upd_word = mem_rd_q;
		if (mode_q == MODE_PROMOTE) begin
			if (idx_s1 == match_idx_q) begin
				upd_word.rank = '0;
				if (act_q == ACT_SET) begin
					upd_word.value = val_q;
				end
			end else if (mem_rd_q.valid && (mem_rd_q.rank < match_rank_q)) begin
				upd_word.rank = mem_rd_q.rank + 1'b1;
			end
		end else begin
			if (idx_s1 == ins_idx_q) begin
				upd_word.valid = 1'b1;
				upd_word.rank  = '0;
				upd_word.key   = key_q;
				upd_word.value = val_q;
			end else if (vic_en_q && (idx_s1 == vic_idx_q)) begin
				upd_word.valid = 1'b0;
			end else if (mem_rd_q.valid) begin
				upd_word.rank = mem_rd_q.rank + 1'b1;
			end
		end
	end

	// Decide what the request does once the scan has seen every entry.
	always_comb begin
		cap_eff   = (CMPW'(capacity_q) > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES)
		                                                     : CMPW'(capacity_q);
		over_cap  = (CMPW'(count_q) + CMPW'(1)) > cap_eff;
		mode_d    = MODE_NONE;
		vic_en_d  = 1'b0;
		count_d   = count_q;
		if (match_q) begin
			mode_d = MODE_PROMOTE;
		end else if (act_q == ACT_SET) begin
			if (over_cap) begin
				if (count_q != '0) begin
					mode_d   = MODE_INSERT;
					vic_en_d = 1'b1;
				end
			end else if (free_q) begin
				mode_d  = MODE_INSERT;
				count_d = count_q + 1'b1;
			end
		end
		// The insert goes to the first slot that is free once the victim is gone.
		ins_idx_d = (vic_en_d && (!free_q || (vic_idx_q < free_idx_q))) ? vic_idx_q
		                                                                 : free_idx_q;
	end

	// Sequencer, scan accumulators and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			vic_q       <= 1'b0;
			mode_q      <= MODE_NONE;
			vic_en_q    <= 1'b0;
		end else begin
			// The output register empties when its transaction is taken; the finish state refills it.
			if (out_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q[IW-1:0] == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						act_q   <= s_axis_tuser;
						key_q   <= s_axis_tdata[KEY_W-1:0];
						val_q   <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
						match_q <= 1'b0;
						free_q  <= 1'b0;
						vic_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (vld_s1) begin
						if (mem_rd_q.valid && (mem_rd_q.key == key_q) && !match_q) begin
							match_q      <= 1'b1;
							match_idx_q  <= idx_s1;
							match_rank_q <= mem_rd_q.rank;
							match_val_q  <= mem_rd_q.value;
						end
						if (!mem_rd_q.valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (mem_rd_q.valid && (!vic_q || (mem_rd_q.rank > vic_rank_q))) begin
							vic_q      <= 1'b1;
							vic_idx_q  <= idx_s1;
							vic_rank_q <= mem_rd_q.rank;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					mode_q    <= mode_d;
					vic_en_q  <= vic_en_d;
					ins_idx_q <= ins_idx_d;
					count_q   <= count_d;
					res_hit_q <= match_q;
					res_rd_q  <= ((act_q == ACT_GET) && match_q) ? match_val_q : MISS_VALUE;
					res_ev_q  <= (act_q == ACT_SET) && !match_q && over_cap;
					cnt_q     <= '0;
					state_q   <= (mode_d == MODE_NONE) ? ST_FINISH : ST_UPDATE;
				end
				ST_UPDATE: begin
					if (rd_issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (vld_s1 && (idx_s1 == LAST_IDX)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Load the result once the output register is free or being emptied.
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_hit_q   <= res_hit_q;
						out_rd_q    <= res_rd_q;
						out_ev_q    <= res_ev_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A hit never evicts.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser && m_axis_tdata[VAL_W]))
		else $error("result reports both a hit and an eviction");

	// The entry count stays within the store.
	assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(count_q) <= CMPW'(MAX_ENTRIES))
		else $error("entry count exceeds the store size");

	// The entry count changes only when a request is decided.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DECIDE) |=> $stable(count_q))
		else $error("entry count changed outside the decision cycle");

	// A new key that fits under the capacity always finds a free slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DECIDE) && (act_q == ACT_SET) && !match_q && !over_cap) |-> free_q)
		else $error("no free slot for an insert under the capacity");

	// An accepted request always starts a scan pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_SCAN))
		else $error("accepted request did not start a scan");

endmodule
